### hdl/header_framed_byte_receiver_assert.svh
// ----------------------------------------------------------------------------
// header_framed_byte_receiver_assert.svh
// Assertion macros shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef HEADER_FRAMED_BYTE_RECEIVER_ASSERT_SVH
`define HEADER_FRAMED_BYTE_RECEIVER_ASSERT_SVH

// same-cycle implication
`define HFBR_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hfbr assertion failed");

// next-cycle implication
`define HFBR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hfbr assertion failed");

`endif

### hdl/hfbr_pkg.sv
// ----------------------------------------------------------------------------
// hfbr_pkg
// Constants and result type of the header framed byte receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package hfbr_pkg;

    localparam int unsigned PAYLOAD_SLOTS = 9;      // range 2..16
    localparam logic [8:0]  SLOT_LIMIT    = 9'(PAYLOAD_SLOTS);

    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] END_BYTE   = 8'h00;
    localparam logic [1:0] HDR_NEEDED = 2'd2;
    localparam logic [1:0] HDR_MAX    = 2'd3;
    localparam logic [7:0] COUNT_MAX  = 8'd255;

    localparam int unsigned TDATA_W = 24;           // 20 used bits, byte padded
    localparam int unsigned TUSER_W = 4;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] byte_out;
        logic       length_valid;
        logic       payload_valid;
        logic [3:0] payload_index;
        logic       overflow;
        logic       frame_done;
        logic [7:0] frame_count;
    } result_t;

endpackage

`default_nettype wire

### hdl/header_framed_byte_receiver.sv
// Results pass through the output register (and the skid register on a stall) before m_axis.
// Throughput: one byte per cycle while s_axis_tready is high; the state update is a single registered step.
// s_axis_tready is registered and drops only when the two-entry result
// buffer is full, so a stalled result does not block the next byte.
// Reset: aresetn low synchronously returns to header mode, clears counts and
// empties the result buffer.
// ----------------------------------------------------------------------------
// header_framed_byte_receiver
// Byte stream receiver: 0xFF 0xFF header, length byte, payload, 0x00 end.
// ----------------------------------------------------------------------------
`default_nettype none

module header_framed_byte_receiver (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // input stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,   // [7:0] rx_byte
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [7:0] byte_out, [11:8] payload_index, [19:12] frame_count, [23:20] zero
    output logic [hfbr_pkg::TDATA_W-1:0]      m_axis_tdata,
    // [0] echo_valid, [1] length_valid, [2] payload_valid, [3] overflow
    output logic [hfbr_pkg::TUSER_W-1:0]      m_axis_tuser,
    output logic                              m_axis_tlast    // frame_done
);
    import hfbr_pkg::*;

    // frame state
    logic       in_data_mode_reg, in_data_mode_next;
    logic [1:0] header_count_reg, header_count_next;
    logic [7:0] byte_count_reg,   byte_count_next;

    logic       s_fire;
    logic       data_byte;
    logic [7:0] byte_inc;
    logic [7:0] slot;
    logic [7:0] rx_byte;
    result_t    res;
    result_t    res_out;

    assign rx_byte = s_axis_tdata;

    // One-pass decode of the current byte against the frame state.
    always_comb begin
        res                = '0;
        res.byte_out       = rx_byte;
        in_data_mode_next  = in_data_mode_reg;
        header_count_next  = header_count_reg;
        byte_count_next    = byte_count_reg;
        data_byte          = in_data_mode_reg;
        byte_inc           = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                           : byte_count_reg + 8'd1;
        slot               = byte_inc - 8'd1;

        // header hunt: count 0xFF (saturating), a non-0xFF byte after
        // exactly two of them is the first data byte
        if (!in_data_mode_reg) begin
            if (rx_byte == HDR_BYTE) begin
                res.echo_valid = 1'b1;
                if (header_count_reg != HDR_MAX) begin
                    header_count_next = header_count_reg + 2'd1;
                end
            end else if (header_count_reg != HDR_NEEDED) begin
                header_count_next = '0;
            end else begin
                data_byte = 1'b1;
            end
        end

        if (data_byte) begin
            res.echo_valid = 1'b1;
            if (rx_byte == END_BYTE) begin
                // terminator closes the frame and rearms the header hunt
                res.frame_done    = 1'b1;
                res.frame_count   = byte_count_reg;
                byte_count_next   = '0;
                header_count_next = '0;
                in_data_mode_next = 1'b0;
            end else begin
                in_data_mode_next = 1'b1;
                byte_count_next   = byte_inc;
                if (byte_inc == 8'd1) begin
                    res.length_valid = 1'b1;
                end else if ({1'b0, slot} < SLOT_LIMIT) begin
                    res.payload_valid = 1'b1;
                    res.payload_index = slot[3:0];
                end else begin
                    res.overflow = 1'b1;   // slot past buffer, not stored
                end
            end
        end
    end

    assign s_fire = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_data_mode_reg <= 1'b0;
            header_count_reg <= '0;
            byte_count_reg   <= '0;
        end else if (s_fire) begin
            in_data_mode_reg <= in_data_mode_next;
            header_count_reg <= header_count_next;
            byte_count_reg   <= byte_count_next;
        end
    end

    // result register and skid stage
    hfbr_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_out)
    );

    assign m_axis_tdata = {4'd0, res_out.frame_count, res_out.payload_index,
                           res_out.byte_out};
    assign m_axis_tuser = {res_out.overflow, res_out.payload_valid,
                           res_out.length_valid, res_out.echo_valid};
    assign m_axis_tlast = res_out.frame_done;

`include "header_framed_byte_receiver_assert.svh"

    // byte count only grows inside a frame
    `HFBR_ASSERT_NOW(a_count_in_frame, aclk, aresetn, byte_count_reg != 8'd0, in_data_mode_reg)
    // a terminator in data mode fully rearms the header hunt
    `HFBR_ASSERT_NEXT(a_end_rearms, aclk, aresetn, s_fire && in_data_mode_reg && (rx_byte == END_BYTE), !in_data_mode_reg && (byte_count_reg == 8'd0) && (header_count_reg == 2'd0))
    // data mode is only entered from exactly two header bytes
    `HFBR_ASSERT_NOW(a_data_after_hdr, aclk, aresetn, in_data_mode_reg, header_count_reg == HDR_NEEDED)

endmodule

`default_nettype wire

### hdl/hfbr_out_buf.sv
// ----------------------------------------------------------------------------
// hfbr_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none

module hfbr_out_buf (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire hfbr_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output hfbr_pkg::result_t     out_data
);
    import hfbr_pkg::*;

    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    in_fire;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign pop       = out_valid_reg && out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_reg <= skid_valid_reg ? skid_reg : in_data;
        end
        if (out_valid_reg && !pop && in_fire) begin
            skid_reg <= in_data;
        end
    end

`include "header_framed_byte_receiver_assert.svh"

    `HFBR_ASSERT_NOW(a_skid_needs_out, aclk, aresetn, skid_valid_reg, out_valid_reg)
    `HFBR_ASSERT_NEXT(a_stall_fills_skid, aclk, aresetn, in_fire && out_valid_reg && !out_ready, skid_valid_reg)
    `HFBR_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg)

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the header framed byte receiver. A directed table
// walks the header counter, the terminator and the payload slots; random
// frames then run under several idle/stall mixes. Every result transaction is
// compared field by field against a cycle-free model of the frame decoder or a hand-typed row.
// ----------------------------------------------------------------------------

module tb_top;

    import hfbr_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;  // far above the slowest legal run
    localparam int unsigned PHASE_ITEMS  = 85;      // echoed bytes per idle/stall phase
    localparam int unsigned LONG_PAYLOAD = 265;     // drives the byte count into saturation at 255
    localparam int unsigned HOLD_CYCLES  = 40;      // receiver back-pressure stretch

    // one directed row: the byte, and a hand-typed report where it is obvious
    typedef struct {
        logic [7:0] rx_byte;
        bit         typed;
        result_t    want;
    } dir_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [TDATA_W-1:0]   m_axis_tdata;
    logic [TUSER_W-1:0]   m_axis_tuser;
    logic                 m_axis_tlast;

    // decoder model state
    logic                 in_frame;
    logic [1:0]           hdr_seen;
    logic [7:0]           frame_bytes;

    result_t              byte_reports[$];   // reports still owed by the block
    dir_row_t             dir_rows[$];
    int unsigned          mismatches;
    int unsigned          echoed;
    int unsigned          cycles;
    int unsigned          idle_pct;
    int unsigned          stall_pct;
    int unsigned          hold_left;

    header_framed_byte_receiver i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Decoder model: one report per byte, state carried across calls.
    // ------------------------------------------------------------------------
    function automatic result_t decode_byte(input logic [7:0] b);
        result_t    r;
        logic [7:0] slot;
        r = '0;
        r.byte_out = b;
        if (!in_frame) begin
            if (b == HDR_BYTE) begin
                r.echo_valid = 1'b1;
                if (hdr_seen != HDR_MAX) hdr_seen = hdr_seen + 2'd1;   // saturates
            end else if (hdr_seen != HDR_NEEDED) begin
                hdr_seen = '0;              // bad header, byte dropped
            end else begin
                in_frame = 1'b1;            // this byte is handled as data below
            end
        end
        if (in_frame) begin
            r.echo_valid = 1'b1;
            if (b == END_BYTE) begin
                r.frame_done  = 1'b1;
                r.frame_count = frame_bytes;
                frame_bytes   = '0;
                hdr_seen      = '0;
                in_frame      = 1'b0;
            end else begin
                if (frame_bytes != COUNT_MAX) frame_bytes = frame_bytes + 8'd1;
                if (frame_bytes == 8'd1) begin
                    r.length_valid = 1'b1;
                end else begin
                    slot = frame_bytes - 8'd1;
                    if (9'(slot) < SLOT_LIMIT) begin
                        r.payload_valid = 1'b1;
                        r.payload_index = slot[3:0];
                    end else begin
                        r.overflow = 1'b1;  // past the buffer, not stored
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic result_t rpt(input bit echo, input logic [7:0] b, input bit len,
                                    input bit pay, input logic [3:0] idx, input bit ovf,
                                    input bit done, input logic [7:0] cnt);
        result_t r;
        r.echo_valid    = echo;
        r.byte_out      = b;
        r.length_valid  = len;
        r.payload_valid = pay;
        r.payload_index = idx;
        r.overflow      = ovf;
        r.frame_done    = done;
        r.frame_count   = cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Input side. Called at a falling edge; returns at a falling edge after
    // the transaction was taken. tvalid stays high between back-to-back bytes.
    // The report is queued before the byte can be accepted, so the checker
    // never sees a result ahead of its expectation.
    // ------------------------------------------------------------------------
    task automatic offer_byte(input logic [7:0] b, input result_t want);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        byte_reports.push_back(want);
        if (want.echo_valid) echoed++;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
    endtask

    task automatic send_rx(input logic [7:0] b);
        offer_byte(b, decode_byte(b));
    endtask

    // sender goes quiet until every owed report has come back
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (byte_reports.size() != 0) @(negedge aclk);
    endtask

    // Mostly well-formed frames with random content; the rest are header
    // faults and line noise, some of which leave the block in data mode.
    task automatic send_random_frame();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(99);
        if (kind < 78) begin
            send_rx(HDR_BYTE);
            send_rx(HDR_BYTE);
            send_rx(8'($urandom_range(255, 1)));            // length byte, never 0x00
            n = ($urandom_range(7) == 0) ? $urandom_range(14) : $urandom_range(8);
            repeat (n) send_rx(8'($urandom_range(255, 1)));
            send_rx(END_BYTE);
        end else if (kind < 84) begin
            // terminator straight after the header
            send_rx(HDR_BYTE);
            send_rx(HDR_BYTE);
            send_rx(END_BYTE);
        end else if (kind < 90) begin
            // three or more header bytes, then a byte that must clear the count
            repeat ($urandom_range(5, 3)) send_rx(HDR_BYTE);
            send_rx(8'($urandom_range(254)));
        end else begin
            repeat ($urandom_range(4, 1)) send_rx(8'($urandom_range(255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: tready changes on falling edges; a long hold-off is
    // counted here so the input side keeps offering while the buffer fills.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // result transactions, compared against the oldest owed report
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (byte_reports.size() == 0) begin
                $error("result transaction with no byte outstanding: tdata 0x%0h",
                       m_axis_tdata);
                mismatches++;
            end else begin
                want = byte_reports.pop_front();
                check_field("echo_valid",    8'(want.echo_valid),    8'(m_axis_tuser[0]));
                check_field("byte_out",      want.byte_out,          m_axis_tdata[7:0]);
                check_field("length_valid",  8'(want.length_valid),  8'(m_axis_tuser[1]));
                check_field("payload_valid", 8'(want.payload_valid), 8'(m_axis_tuser[2]));
                check_field("payload_index", 8'(want.payload_index), 8'(m_axis_tdata[11:8]));
                check_field("overflow",      8'(want.overflow),      8'(m_axis_tuser[3]));
                check_field("frame_done",    8'(want.frame_done),    8'(m_axis_tlast));
                check_field("frame_count",   want.frame_count,       m_axis_tdata[19:12]);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reports outstanding",
                     cycles, byte_reports.size());
            $display("** header_framed_byte_receiver: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial begin
        result_t want;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        in_frame      = 1'b0;
        hdr_seen      = '0;
        frame_bytes   = '0;
        mismatches    = 0;
        echoed        = 0;
        cycles        = 0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_left     = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed table. Typed rows are the ones readable at a glance;
        // zero rows fall back to the model.
        dir_rows.push_back('{8'h00, 1'b1, rpt(0, 8'h00, 0, 0, 0, 0, 0, 0)}); // dropped
        dir_rows.push_back('{HDR_BYTE, 1'b1, rpt(1, HDR_BYTE, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{HDR_BYTE, 1'b1, rpt(1, HDR_BYTE, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{HDR_BYTE, 1'b1, rpt(1, HDR_BYTE, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{HDR_BYTE, 1'b1, rpt(1, HDR_BYTE, 0, 0, 0, 0, 0, 0)}); // sat
        dir_rows.push_back('{8'h12, 1'b1, rpt(0, 8'h12, 0, 0, 0, 0, 0, 0)});    // too many FF
        dir_rows.push_back('{HDR_BYTE, 1'b0, '0});
        dir_rows.push_back('{HDR_BYTE, 1'b0, '0});
        dir_rows.push_back('{END_BYTE, 1'b1, rpt(1, END_BYTE, 0, 0, 0, 0, 1, 0)}); // empty
        dir_rows.push_back('{HDR_BYTE, 1'b0, '0});
        dir_rows.push_back('{HDR_BYTE, 1'b0, '0});
        dir_rows.push_back('{8'h05, 1'b1, rpt(1, 8'h05, 1, 0, 0, 0, 0, 0)});    // length
        dir_rows.push_back('{8'hFF, 1'b0, '0});                                  // FF as data
        dir_rows.push_back('{8'h80, 1'b0, '0});
        dir_rows.push_back('{8'h7F, 1'b0, '0});
        dir_rows.push_back('{8'h01, 1'b0, '0});
        dir_rows.push_back('{8'hAA, 1'b0, '0});
        dir_rows.push_back('{8'h55, 1'b0, '0});
        dir_rows.push_back('{8'hFE, 1'b0, '0});
        dir_rows.push_back('{8'h3C, 1'b0, '0});                                  // last slot
        dir_rows.push_back('{8'h99, 1'b1, rpt(1, 8'h99, 0, 0, 0, 1, 0, 0)});    // overflow
        dir_rows.push_back('{END_BYTE, 1'b0, '0});
        dir_rows.push_back('{HDR_BYTE, 1'b0, '0});
        dir_rows.push_back('{8'h01, 1'b1, rpt(0, 8'h01, 0, 0, 0, 0, 0, 0)});    // one FF only

        foreach (dir_rows[i]) begin
            want = decode_byte(dir_rows[i].rx_byte);
            if (dir_rows[i].typed) want = dir_rows[i].want;
            offer_byte(dir_rows[i].rx_byte, want);
        end
        wait_drain();

        // Long frame under a receiver hold-off: the byte count saturates,
        // the two-entry buffer fills and the input side must stall.
        @(posedge aclk);
        hold_left = HOLD_CYCLES;
        @(negedge aclk);
        send_rx(HDR_BYTE);
        send_rx(HDR_BYTE);
        send_rx(8'($urandom_range(255, 1)));
        repeat (LONG_PAYLOAD) send_rx(8'($urandom_range(255, 1)));
        send_rx(END_BYTE);
        wait_drain();

        // idle/stall mixes: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 63; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 63; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase
            echoed = 0;
            while (echoed < PHASE_ITEMS) send_random_frame();
            wait_drain();
        end

        repeat (4) @(negedge aclk);

        foreach (byte_reports[i]) begin
            $error("report never delivered: byte_out 0x%0h", byte_reports[i].byte_out);
            mismatches++;
        end

        if (mismatches == 0) begin
            $display("** header_framed_byte_receiver: PASSED **");
        end else begin
            $display("** header_framed_byte_receiver: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
+incdir+hdl
hdl/hfbr_pkg.sv
hdl/hfbr_out_buf.sv
hdl/header_framed_byte_receiver.sv
sim/tb_top.sv
